>>> src/midi_running_status_parser_top_assert.svh
// assertion macros for the parser modules, used by the result queue
`ifndef MIDI_RUNNING_STATUS_PARSER_TOP_ASSERT_SVH
`define MIDI_RUNNING_STATUS_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked property, ignored while reset is held
`define MRSP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mrsp assertion failed");
// clocked property, checked during reset as well
`define MRSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mrsp assertion failed");
`else
`define MRSP_ASSERT(label, clk, rstn, prop)
`define MRSP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> src/mrsp_pkg.sv
package mrsp_pkg;

    localparam int PORTS      = 16;
    localparam int PORT_W     = 4;
    localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // event kinds
    localparam logic [3:0] K_REALTIME = 4'd0;
    localparam logic [3:0] K_RAW      = 4'd1;
    localparam logic [3:0] K_SYSEX    = 4'd2;
    localparam logic [3:0] K_NOTEON   = 4'd3;
    localparam logic [3:0] K_POLY     = 4'd4;
    localparam logic [3:0] K_CONTROL  = 4'd5;
    localparam logic [3:0] K_PROGRAM  = 4'd6;
    localparam logic [3:0] K_CHTOUCH  = 4'd7;
    localparam logic [3:0] K_BEND     = 4'd8;

    // status and command bytes
    localparam logic [7:0] ST_NONE     = 8'h00;
    localparam logic [7:0] ST_REALTIME = 8'hf8;
    localparam logic [7:0] ST_SYSEX    = 8'hf0;
    localparam logic [7:0] ST_EOX      = 8'hf7;
    localparam logic [7:0] ST_F4       = 8'hf4;
    localparam logic [7:0] ST_F5       = 8'hf5;
    localparam logic [7:0] ST_F6       = 8'hf6;
    localparam logic [7:0] CMD_MASK    = 8'hf0;
    localparam logic [7:0] CMD_NOTEOFF = 8'h80;
    localparam logic [7:0] CMD_NOTEON  = 8'h90;
    localparam logic [7:0] CMD_POLY    = 8'ha0;
    localparam logic [7:0] CMD_CONTROL = 8'hb0;
    localparam logic [7:0] CMD_PROGRAM = 8'hc0;
    localparam logic [7:0] CMD_CHTOUCH = 8'hd0;
    localparam logic [7:0] CMD_BEND    = 8'he0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [3:0]  event_port;
        logic [3:0]  channel;
        logic [7:0]  first_value;
        logic [13:0] second_value;
        logic        last;
    } result_t;

    // per-port parser state as seen by the decoder
    typedef struct packed {
        logic [7:0] status;
        logic       pending;
        logic [6:0] first_data;
    } port_state_t;

    // state update for the port in flight
    typedef struct packed {
        logic       st_we;
        logic [7:0] status;
        logic       pending;
        logic       fd_we;
        logic [6:0] first_data;
    } state_wr_t;

    // decoder output: up to two results and the state update
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
        state_wr_t  wr;
    } decode_t;

endpackage

>>> src/mrsp_port_state.sv
module mrsp_port_state (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [mrsp_pkg::PORT_W-1:0] port,
    input  logic                        wr_en,
    input  mrsp_pkg::state_wr_t         wr,
    output mrsp_pkg::port_state_t       rd
);
    import mrsp_pkg::*;

    logic [7:0] status_reg  [PORTS];
    logic       pending_reg [PORTS];
    logic [6:0] first_reg   [PORTS];
    logic [PORT_IDX_W-1:0] idx;

    assign idx = PORT_IDX_W'(port);

    assign rd.status     = status_reg[idx];
    assign rd.pending    = pending_reg[idx];
    assign rd.first_data = first_reg[idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PORTS; i++) begin
                status_reg[i]  <= ST_NONE;
                pending_reg[i] <= 1'b0;
            end
        end else if (wr_en && wr.st_we) begin
            status_reg[idx]  <= wr.status;
            pending_reg[idx] <= wr.pending;
        end
    end

    // first data byte is only read while pending, so it needs no reset
    always_ff @(posedge aclk) begin
        if (wr_en && wr.fd_we) begin
            first_reg[idx] <= wr.first_data;
        end
    end

endmodule

>>> src/mrsp_decode.sv
module mrsp_decode (
    input  logic [mrsp_pkg::PORT_W-1:0] port,
    input  logic [7:0]                  data_byte,
    input  mrsp_pkg::port_state_t       st,
    output mrsp_pkg::decode_t           dec
);
    import mrsp_pkg::*;

    logic [7:0] cmd;
    logic [3:0] chan;
    logic       port_ok;
    logic       chan_two;

    assign port_ok  = (int'(port) < PORTS);
    assign cmd      = (st.status >= CMD_MASK) ? st.status : (st.status & CMD_MASK);
    assign chan     = st.status[3:0];
    assign chan_two = (cmd == CMD_NOTEOFF) || (cmd == CMD_NOTEON) || (cmd == CMD_POLY) ||
                      (cmd == CMD_CONTROL) || (cmd == CMD_BEND);

    always_comb begin
        dec = '0;
        // raw byte event is the first result, except for real-time bytes
        dec.r0.event_kind  = K_RAW;
        dec.r0.event_port  = port;
        dec.r0.first_value = data_byte;
        dec.r1.event_port  = port;
        dec.r1.first_value = data_byte;
        dec.r1.last        = 1'b1;
        dec.wr.status      = st.status;
        dec.wr.pending     = st.pending;
        dec.wr.first_data  = data_byte[6:0];

        priority if (!port_ok) begin
            dec.count = 2'd0;
        end else if (data_byte >= ST_REALTIME) begin
            dec.count         = 2'd1;
            dec.r0.event_kind = K_REALTIME;
        end else if (data_byte[7]) begin
            // status byte: always drops a pending first byte
            dec.wr.st_we   = 1'b1;
            dec.wr.pending = 1'b0;
            if ((data_byte == ST_EOX) || (data_byte == ST_F4) ||
                (data_byte == ST_F5) || (data_byte == ST_F6)) begin
                dec.wr.status = ST_NONE;
            end else begin
                dec.wr.status = data_byte;
            end
            if ((data_byte == ST_SYSEX) || (data_byte == ST_EOX)) begin
                dec.count         = 2'd2;
                dec.r1.event_kind = K_SYSEX;
            end else begin
                dec.count = 2'd1;
            end
        end else if (cmd == ST_SYSEX) begin
            dec.count         = 2'd2;
            dec.r1.event_kind = K_SYSEX;
        end else if ((cmd == CMD_PROGRAM) || (cmd == CMD_CHTOUCH)) begin
            dec.count         = 2'd2;
            dec.r1.event_kind = (cmd == CMD_PROGRAM) ? K_PROGRAM : K_CHTOUCH;
            dec.r1.channel    = chan;
        end else if (chan_two && !st.pending) begin
            // hold the first data byte
            dec.count      = 2'd1;
            dec.wr.st_we   = 1'b1;
            dec.wr.pending = 1'b1;
            dec.wr.fd_we   = 1'b1;
        end else if (chan_two) begin
            dec.count          = 2'd2;
            dec.wr.st_we       = 1'b1;
            dec.wr.pending     = 1'b0;
            dec.r1.channel     = chan;
            dec.r1.first_value = {1'b0, st.first_data};
            unique case (cmd)
                CMD_BEND: begin
                    dec.r1.event_kind   = K_BEND;
                    dec.r1.second_value = {data_byte[6:0], st.first_data};
                end
                CMD_NOTEOFF: begin
                    // note off goes out as note on, velocity zero
                    dec.r1.event_kind   = K_NOTEON;
                    dec.r1.second_value = '0;
                end
                CMD_NOTEON: begin
                    dec.r1.event_kind   = K_NOTEON;
                    dec.r1.second_value = {7'd0, data_byte[6:0]};
                end
                CMD_POLY: begin
                    dec.r1.event_kind   = K_POLY;
                    dec.r1.second_value = {7'd0, data_byte[6:0]};
                end
                default: begin
                    dec.r1.event_kind   = K_CONTROL;
                    dec.r1.second_value = {7'd0, data_byte[6:0]};
                end
            endcase
        end else begin
            // no status or system common status: data dropped
            dec.count = 2'd1;
        end

        dec.r0.last = (dec.count == 2'd1);
    end

endmodule

>>> src/mrsp_result_fifo.sv
`include "midi_running_status_parser_top_assert.svh"

module mrsp_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_n,
    input  mrsp_pkg::result_t push_r0,
    input  mrsp_pkg::result_t push_r1,
    output logic              room2,
    output logic              out_valid,
    input  logic              out_ready,
    output mrsp_pkg::result_t out_word
);
    import mrsp_pkg::*;

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FIFO_DEPTH; i++) begin
            if ((push_n != 2'd0) && (FIFO_PTR_W'(i) == wr_ptr_reg)) begin
                mem_reg[i] <= push_r0;
            end
            if ((push_n == 2'd2) && (FIFO_PTR_W'(i) == wr_ptr_p1)) begin
                mem_reg[i] <= push_r1;
            end
        end
    end

    `MRSP_ASSERT(a_count_bound, aclk, aresetn, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `MRSP_ASSERT(a_push_room, aclk, aresetn, (push_n != 2'd0) |-> room2)
    `MRSP_ASSERT(a_pop_only, aclk, aresetn, (pop && (push_n == 2'd0)) |=> (count_reg == $past(count_reg) - 1'b1))

endmodule

>>> src/midi_running_status_parser_top.sv
// flow: a word is taken into the input register, decoded there, and its one or two
//   results are pushed into the result queue; one word per cycle enters while the queue
//   has room for two results, and results leave at one per cycle while m_tready is high
// reset: aresetn synchronous active low, clears running status and pending flags
//   of every port and empties the input register and result queue at once
module midi_running_status_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // port[3:0], data_byte[11:4], zero[15:12]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // event_port[3:0], channel[7:4],
                                   // first_value[15:8], second_value[29:16], zero[31:30]
    output logic [3:0]  m_tuser,   // event_kind[3:0]
    output logic        m_tlast    // last result of this input word
);
    import mrsp_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [PORT_W-1:0] in_port_reg;
    logic [7:0]        in_byte_reg;
    logic              s_take;

    // processing
    logic        fire;
    logic        room2;
    port_state_t st_rd;
    decode_t     dec;
    logic [1:0]  push_n;
    result_t     out_word;

    assign s_take   = s_tvalid && s_tready;
    // the word in the register is processed once the queue has space for two results
    assign fire     = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || fire;
    assign push_n   = fire ? dec.count : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_port_reg <= s_tdata[3:0];
            in_byte_reg <= s_tdata[11:4];
        end
    end

    // per-port running status, pending flag and held first byte
    mrsp_port_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .port    (in_port_reg),
        .wr_en   (fire),
        .wr      (dec.wr),
        .rd      (st_rd)
    );

    // byte classification and message assembly
    mrsp_decode u_decode (
        .port      (in_port_reg),
        .data_byte (in_byte_reg),
        .st        (st_rd),
        .dec       (dec)
    );

    // result queue parts the two sides of the block
    mrsp_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_r0   (dec.r0),
        .push_r1   (dec.r1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {2'b00, out_word.second_value, out_word.first_value,
                      out_word.channel, out_word.event_port};
    assign m_tuser = out_word.event_kind;
    assign m_tlast = out_word.last;

endmodule
